FILE: rtl/gdfo_pkg.sv
package gdfo_pkg;

  localparam int VTX_W      = 10;
  localparam int CFG_W      = 11;
  localparam int MODE_W     = 2;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  localparam int DEF_MAX_VERTICES = 1024;
  localparam int DEF_MAX_EDGES    = 4096;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_NEXT  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

endpackage

FILE: rtl/gdfo_ram.sv
module gdfo_ram #(
  parameter int WIDTH = gdfo_pkg::VTX_W,
  parameter int DEPTH = gdfo_pkg::DEF_MAX_VERTICES
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/gdfo_alu.sv
module gdfo_alu #(
  parameter int WIDTH = gdfo_pkg::CFG_W
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output logic [WIDTH-1:0] sum,
  output logic             lt
);

  logic [WIDTH:0] diff;

  assign sum  = a + b;
  // borrow out of the subtract gives the unsigned less-than
  assign diff = {1'b0, a} - {1'b0, b};
  assign lt   = diff[WIDTH];

endmodule

FILE: rtl/graph_depth_first_order.sv
// Depth-first preorder engine. Load items (mode 0) append adjacency entries, grouped by
// owner vertex in ascending order; bad or excess entries are dropped and set the sticky
// overflow bit. Next items (mode 1) return one vertex of the preorder each, or valid_res 0
// once the order is done; clear items (mode 2) wipe graph and walk. Only next items give a
// result. All work runs through one add/compare unit and simple dual-port memories with
// registered reads, one step per cycle: a load checks owner order, owner range, neighbor
// range and edge space in turn and then writes; a next item steps through stack reads,
// list checks, edge reads and visited checks, or scans roots when the stack is empty,
// and holds its last step while an earlier result is still waiting. After reset and
// after each clear item the block sweeps its list and visited memories with s_tready
// low; write vertex_count only while no item is in flight.
module graph_depth_first_order #(
  parameter int MAX_VERTICES = gdfo_pkg::DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = gdfo_pkg::DEF_MAX_EDGES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [gdfo_pkg::CFG_W-1:0]      cfg_wdata,   // vertex_count
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [gdfo_pkg::IN_DATA_W-1:0]  s_tdata,     // owner, neighbor
  input  logic [gdfo_pkg::MODE_W-1:0]     s_tuser,     // mode
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [gdfo_pkg::OUT_DATA_W-1:0] m_tdata,     // vertex, overflow
  output logic [0:0]                      m_tuser,     // valid_res
  output logic                            m_tlast
);

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int EW  = $clog2(MAX_EDGES);
  localparam int PW  = EW + 1;
  localparam int LW  = EW + PW;
  localparam int SW  = VW + PW;
  localparam int AW0 = (PW > VCW) ? PW : VCW;
  localparam int AW  = (AW0 > gdfo_pkg::CFG_W) ? AW0 : gdfo_pkg::CFG_W;
  localparam int XW  = gdfo_pkg::VTX_W;
  localparam int CW  = gdfo_pkg::CFG_W;

  typedef enum logic [14:0] {
    ST_IDLE     = 15'b000000000000001,
    ST_CLR      = 15'b000000000000010,
    ST_LD_A     = 15'b000000000000100,
    ST_LD_B     = 15'b000000000001000,
    ST_LD_C     = 15'b000000000010000,
    ST_LD_D     = 15'b000000000100000,
    ST_NX_TOP   = 15'b000000001000000,
    ST_NX_TOPD  = 15'b000000010000000,
    ST_NX_LIST  = 15'b000000100000000,
    ST_NX_ADDR  = 15'b000001000000000,
    ST_NX_EDGE  = 15'b000010000000000,
    ST_NX_VIS   = 15'b000100000000000,
    ST_ROOT     = 15'b001000000000000,
    ST_ROOT_CHK = 15'b010000000000000,
    ST_EMIT     = 15'b100000000000000
  } state_t;

  state_t state;

  logic [CW-1:0]  vertex_count;
  logic [CW-1:0]  n;
  logic [XW-1:0]  owner_r;
  logic [XW-1:0]  nb_r;
  logic [XW-1:0]  prev_owner;
  logic [PW-1:0]  edges_loaded;
  logic [VCW-1:0] stack_depth;
  logic [VCW-1:0] emitted;
  logic [CW-1:0]  root_scan;
  logic           overflow_flag;
  logic           drop;
  logic           w_ok;
  logic           res_ok;
  logic [VW-1:0]  clr_addr;
  logic [VW-1:0]  tv;
  logic [PW-1:0]  tp;
  logic [VW-1:0]  w_r;
  logic [VW-1:0]  cand;

  gdfo_pkg::mode_t in_mode;

  logic [AW-1:0] alu_a;
  logic [AW-1:0] alu_b;
  logic [AW-1:0] alu_sum;
  logic          alu_lt;

  logic          clearing;
  logic          load_phase;
  logic          load_drop;
  logic          do_visit;
  logic [VW-1:0] visit_v;

  logic          list_we;
  logic [VW-1:0] list_waddr;
  logic [LW-1:0] list_wdata;
  logic [VW-1:0] list_raddr;
  logic [LW-1:0] list_rdata;
  logic [PW-1:0] list_count;
  logic [EW-1:0] list_first;

  logic          edge_we;
  logic [XW-1:0] edge_rdata;

  logic          vis_we;
  logic [VW-1:0] vis_waddr;
  logic          vis_wdata;
  logic [VW-1:0] vis_raddr;
  logic          vis_rdata;

  logic          stack_we;
  logic [VW-1:0] stack_waddr;
  logic [SW-1:0] stack_wdata;
  logic [SW-1:0] stack_rdata;
  logic [PW-1:0] stack_rd_p;
  logic [VW-1:0] stack_rd_v;

  assign in_mode  = gdfo_pkg::mode_t'(s_tuser);
  assign s_tready = (state == ST_IDLE);

  // vertex_count 0 acts as 1, above the store size as the store size
  always_comb begin
    if (vertex_count == '0) begin
      n = CW'(1);
    end else if (32'(vertex_count) > 32'(MAX_VERTICES)) begin
      n = CW'(MAX_VERTICES);
    end else begin
      n = vertex_count;
    end
  end

  assign list_count = list_rdata[PW-1:0];
  assign list_first = list_rdata[LW-1:PW];
  assign stack_rd_p = stack_rdata[PW-1:0];
  assign stack_rd_v = stack_rdata[SW-1:PW];

  // operand select for the shared add/compare unit
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    unique case (state)
      ST_LD_A: begin
        alu_a = AW'(owner_r);
        alu_b = AW'(prev_owner);
      end
      ST_LD_B: begin
        alu_a = AW'(owner_r);
        alu_b = AW'(n);
      end
      ST_LD_C: begin
        alu_a = AW'(nb_r);
        alu_b = AW'(n);
      end
      ST_LD_D: begin
        alu_a = AW'(edges_loaded);
        alu_b = AW'(MAX_EDGES);
      end
      ST_NX_LIST: begin
        alu_a = AW'(tp);
        alu_b = AW'(list_count);
      end
      ST_NX_ADDR: begin
        alu_a = AW'(list_first);
        alu_b = AW'(tp);
      end
      ST_NX_EDGE: begin
        alu_a = AW'(edge_rdata);
        alu_b = AW'(n);
      end
      ST_ROOT: begin
        alu_a = AW'(root_scan);
        alu_b = AW'(n);
      end
      ST_EMIT: begin
        alu_a = AW'(emitted);
        alu_b = AW'(n);
      end
      default: begin
      end
    endcase
  end

  gdfo_alu #(.WIDTH(AW)) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sum (alu_sum),
    .lt  (alu_lt)
  );

  assign clearing   = (state == ST_CLR);
  assign load_phase = (state == ST_LD_A) || (state == ST_LD_B) ||
                      (state == ST_LD_C) || (state == ST_LD_D);
  assign load_drop  = drop || !alu_lt;
  assign do_visit   = ((state == ST_NX_VIS) && w_ok && !vis_rdata) ||
                      ((state == ST_ROOT_CHK) && !vis_rdata);
  assign visit_v    = (state == ST_NX_VIS) ? w_r : cand;

  // adjacency list heads: {first entry, entry count}
  assign list_we    = clearing || ((state == ST_LD_D) && !load_drop);
  assign list_waddr = clearing ? clr_addr : VW'(owner_r);
  assign list_wdata = clearing ? '0 :
                      {((list_count == '0) ? EW'(edges_loaded) : list_first),
                       list_count + PW'(1)};
  assign list_raddr = load_phase ? VW'(owner_r) :
                      ((state == ST_NX_TOPD) ? stack_rd_v : tv);

  gdfo_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES)) u_list_ram (
    .clk   (clk),
    .we    (list_we),
    .waddr (list_waddr),
    .wdata (list_wdata),
    .raddr (list_raddr),
    .rdata (list_rdata)
  );

  assign edge_we = (state == ST_LD_D) && !load_drop;

  gdfo_ram #(.WIDTH(XW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (EW'(edges_loaded)),
    .wdata (nb_r),
    .raddr (alu_sum[EW-1:0]),
    .rdata (edge_rdata)
  );

  assign vis_we    = clearing || do_visit;
  assign vis_waddr = clearing ? clr_addr : visit_v;
  assign vis_wdata = !clearing;
  assign vis_raddr = (state == ST_NX_EDGE) ? VW'(edge_rdata) : VW'(root_scan);

  gdfo_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_vis_ram (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .raddr (vis_raddr),
    .rdata (vis_rdata)
  );

  // stack entries: {vertex, next list position}
  assign stack_we    = do_visit || ((state == ST_NX_LIST) && alu_lt);
  assign stack_waddr = do_visit ? VW'(stack_depth) : VW'(stack_depth - VCW'(1));
  assign stack_wdata = do_visit ? {visit_v, PW'(0)} : {tv, tp + PW'(1)};

  gdfo_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_stack_ram (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_waddr),
    .wdata (stack_wdata),
    .raddr (VW'(stack_depth - VCW'(1))),
    .rdata (stack_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLR;
      clr_addr      <= '0;
      stack_depth   <= '0;
      root_scan     <= '0;
      edges_loaded  <= '0;
      prev_owner    <= '0;
      emitted       <= '0;
      overflow_flag <= 1'b0;
      m_tvalid      <= 1'b0;
      vertex_count  <= gdfo_pkg::CFG_RESET;
    end else begin
      if (cfg_we) begin
        vertex_count <= cfg_wdata;
      end
      // ST_EMIT drives m_tvalid itself
      if (m_tvalid && m_tready && (state != ST_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      if (do_visit) begin
        stack_depth <= stack_depth + VCW'(1);
        emitted     <= emitted + VCW'(1);
        cand        <= visit_v;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            owner_r <= s_tdata[XW-1:0];
            nb_r    <= s_tdata[2*XW-1:XW];
            drop    <= 1'b0;
            unique case (in_mode)
              gdfo_pkg::MODE_LOAD: begin
                state <= ST_LD_A;
              end
              gdfo_pkg::MODE_NEXT: begin
                state <= ST_NX_TOP;
              end
              gdfo_pkg::MODE_CLEAR: begin
                state         <= ST_CLR;
                clr_addr      <= '0;
                stack_depth   <= '0;
                root_scan     <= '0;
                edges_loaded  <= '0;
                prev_owner    <= '0;
                emitted       <= '0;
                overflow_flag <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_CLR: begin
          clr_addr <= clr_addr + VW'(1);
          if (clr_addr == VW'(MAX_VERTICES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_LD_A: begin
          drop  <= alu_lt;
          state <= ST_LD_B;
        end
        ST_LD_B: begin
          if (!alu_lt) begin
            drop <= 1'b1;
          end
          state <= ST_LD_C;
        end
        ST_LD_C: begin
          if (!alu_lt) begin
            drop <= 1'b1;
          end
          state <= ST_LD_D;
        end
        ST_LD_D: begin
          if (load_drop) begin
            overflow_flag <= 1'b1;
          end else begin
            edges_loaded <= edges_loaded + PW'(1);
            prev_owner   <= owner_r;
          end
          state <= ST_IDLE;
        end
        ST_NX_TOP: begin
          if (stack_depth == '0) begin
            state <= ST_ROOT;
          end else begin
            state <= ST_NX_TOPD;
          end
        end
        ST_NX_TOPD: begin
          tv    <= stack_rd_v;
          tp    <= stack_rd_p;
          state <= ST_NX_LIST;
        end
        ST_NX_LIST: begin
          if (alu_lt) begin
            state <= ST_NX_ADDR;
          end else begin
            // list exhausted: pop
            stack_depth <= stack_depth - VCW'(1);
            state       <= ST_NX_TOP;
          end
        end
        ST_NX_ADDR: begin
          tp    <= tp + PW'(1);
          state <= ST_NX_EDGE;
        end
        ST_NX_EDGE: begin
          w_r   <= VW'(edge_rdata);
          w_ok  <= alu_lt;
          state <= ST_NX_VIS;
        end
        ST_NX_VIS: begin
          if (do_visit) begin
            res_ok <= 1'b1;
            state  <= ST_EMIT;
          end else begin
            state <= ST_NX_LIST;
          end
        end
        ST_ROOT: begin
          if (alu_lt) begin
            cand      <= VW'(root_scan);
            root_scan <= root_scan + CW'(1);
            state     <= ST_ROOT_CHK;
          end else begin
            res_ok <= 1'b0;
            state  <= ST_EMIT;
          end
        end
        ST_ROOT_CHK: begin
          if (!vis_rdata) begin
            res_ok <= 1'b1;
            state  <= ST_EMIT;
          end else begin
            state <= ST_ROOT;
          end
        end
        ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{(gdfo_pkg::OUT_DATA_W - XW - 1){1'b0}}, overflow_flag,
                         (res_ok ? XW'(cand) : XW'(0))};
            m_tuser  <= res_ok;
            m_tlast  <= res_ok && !alu_lt;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/gdfo_checker.sv
module gdfo_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            cfg_we,
  input logic [gdfo_pkg::CFG_W-1:0]      cfg_wdata,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [gdfo_pkg::IN_DATA_W-1:0]  s_tdata,
  input logic [gdfo_pkg::MODE_W-1:0]     s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [gdfo_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [0:0]                      m_tuser,
  input logic                            m_tlast
);

  // reset starts the clearing sweep with no result pending
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!m_tvalid && !s_tready))
    else $error("output valid or input ready right after reset");

  // any load, next or clear item keeps the input closed on the following cycle
  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready &&
     (s_tuser == gdfo_pkg::MODE_LOAD || s_tuser == gdfo_pkg::MODE_NEXT ||
      s_tuser == gdfo_pkg::MODE_CLEAR))
    |=> !s_tready)
    else $error("input ready on the cycle after an accepted item");

  // a finished-order answer carries vertex 0 and no last mark
  a_done_answer: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0])
    |-> (!m_tlast && m_tdata[gdfo_pkg::VTX_W-1:0] == '0))
    else $error("empty answer with vertex or last set");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready)
    |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
    else $error("stalled result changed");

endmodule

bind graph_depth_first_order gdfo_checker u_gdfo_checker (.*);
